// File: hw/rtl/frd_pkg.sv
package frd_pkg;

	// default operand width
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOD_LOAD,
		ST_MOD_RUN,
		ST_MOD_WB,
		ST_QN_LOAD,
		ST_QN_RUN,
		ST_QN_WB,
		ST_QD_LOAD,
		ST_QD_RUN,
		ST_QD_WB,
		ST_DONE
	} frd_state_t;

	// operand selection for the shared divider
	typedef enum logic [1:0] {
		DIV_MOD,
		DIV_QN,
		DIV_QD
	} frd_div_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic         load;
		logic         div_load;
		frd_div_sel_t div_sel;
		logic         div_step;
		logic         gcd_wb;
		logic         qn_wb;
		logic         res_wb;
	} frd_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic den_zero;
		logic y_zero;
		logic div_last;
	} frd_status_t;

endpackage

// File: hw/rtl/frd_ctrl.sv
module frd_ctrl
	import frd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  frd_status_t status,
	output frd_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	frd_state_t state_q;
	frd_state_t state_nxt;

	// hold the current state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// advance through the Euclid loop and the two final divisions
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = status.den_zero ? ST_DONE : ST_CHECK;
				end
			end
			ST_CHECK:    state_nxt = status.y_zero ? ST_QN_LOAD : ST_MOD_LOAD;
			ST_MOD_LOAD: state_nxt = ST_MOD_RUN;
			ST_MOD_RUN: begin
				if (status.div_last) begin
					state_nxt = ST_MOD_WB;
				end
			end
			ST_MOD_WB:   state_nxt = ST_CHECK;
			ST_QN_LOAD:  state_nxt = ST_QN_RUN;
			ST_QN_RUN: begin
				if (status.div_last) begin
					state_nxt = ST_QN_WB;
				end
			end
			ST_QN_WB:    state_nxt = ST_QD_LOAD;
			ST_QD_LOAD:  state_nxt = ST_QD_RUN;
			ST_QD_RUN: begin
				if (status.div_last) begin
					state_nxt = ST_QD_WB;
				end
			end
			ST_QD_WB:    state_nxt = ST_DONE;
			ST_DONE:     state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// drive datapath commands from the state
	always_comb begin
		cmd          = '0;
		cmd.div_sel  = DIV_MOD;
		busy         = 1'b1;
		done         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CHECK: ;
			ST_MOD_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = DIV_MOD;
			end
			ST_MOD_RUN:  cmd.div_step = 1'b1;
			ST_MOD_WB:   cmd.gcd_wb   = 1'b1;
			ST_QN_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = DIV_QN;
			end
			ST_QN_RUN:   cmd.div_step = 1'b1;
			ST_QN_WB:    cmd.qn_wb    = 1'b1;
			ST_QD_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = DIV_QD;
			end
			ST_QD_RUN:   cmd.div_step = 1'b1;
			ST_QD_WB:    cmd.res_wb   = 1'b1;
			ST_DONE:     done         = 1'b1;
			default:     busy         = 1'b1;
		endcase
	end

endmodule

// File: hw/rtl/frd_dp.sv
module frd_dp
	import frd_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic signed [VALUE_WIDTH-1:0] numerator,
	input  logic signed [VALUE_WIDTH-1:0] denominator,
	input  frd_cmd_t                      cmd,
	output frd_status_t                   status,
	output logic signed [VALUE_WIDTH-1:0] reduced_numerator,
	output logic signed [VALUE_WIDTH-1:0] reduced_denominator,
	output logic                          zero_denominator,
	output logic                          whole_number
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned CW = $clog2(W);
	localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

	logic [W-1:0] mn_q;
	logic [W-1:0] md_q;
	logic [W-1:0] x_q;
	logic [W-1:0] y_q;
	logic [W-1:0] qn_q;
	logic         neg_q;

	logic [W-1:0]  dvd_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0] num_mag;
	logic [W-1:0] den_mag;
	logic [W:0]   rem_ext;
	logic [W:0]   diff;
	logic [W-1:0] out_num;

	logic signed [W-1:0] rn_q;
	logic signed [W-1:0] rd_q;
	logic                zd_q;
	logic                wn_q;

	// magnitudes of the incoming parts
	assign num_mag = numerator[W-1] ? (~numerator + 1'b1) : numerator;
	assign den_mag = denominator[W-1] ? (~denominator + 1'b1) : denominator;

	// one restoring division step
	assign rem_ext = {rem_q, dvd_q[W-1]};
	assign diff    = rem_ext - {1'b0, dvs_q};

	// apply the combined sign unless the numerator reduced to zero
	assign out_num = (neg_q && (qn_q != '0)) ? (~qn_q + 1'b1) : qn_q;

	assign status.den_zero = (denominator == '0);
	assign status.y_zero   = (y_q == '0);
	assign status.div_last = (cnt_q == CNT_LAST);

	// operand and gcd registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mn_q  <= num_mag;
			md_q  <= den_mag;
			x_q   <= den_mag;
			y_q   <= num_mag;
			neg_q <= numerator[W-1] ^ denominator[W-1];
		end else if (cmd.gcd_wb) begin
			x_q <= y_q;
			y_q <= rem_q;
		end
		if (cmd.qn_wb) begin
			qn_q <= dvd_q;
		end
	end

	// shared serial divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			cnt_q <= '0;
			case (cmd.div_sel)
				DIV_MOD: begin
					dvd_q <= x_q;
					dvs_q <= y_q;
				end
				DIV_QN: begin
					dvd_q <= mn_q;
					dvs_q <= x_q;
				end
				DIV_QD: begin
					dvd_q <= md_q;
					dvs_q <= x_q;
				end
				default: begin
					dvd_q <= x_q;
					dvs_q <= y_q;
				end
			endcase
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				dvd_q <= {dvd_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_ext[W-1:0];
				dvd_q <= {dvd_q[W-2:0], 1'b0};
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.load && status.den_zero) begin
			rn_q <= numerator;
			rd_q <= '0;
			zd_q <= 1'b1;
			wn_q <= 1'b0;
		end else if (cmd.res_wb) begin
			rn_q <= out_num;
			rd_q <= dvd_q;
			zd_q <= 1'b0;
			wn_q <= (dvd_q == W'(1));
		end
	end

	assign reduced_numerator   = rn_q;
	assign reduced_denominator = rd_q;
	assign zero_denominator    = zd_q;
	assign whole_number        = wn_q;

endmodule

// File: hw/rtl/fraction_reduce_core.sv
// Sequence: once start is taken, the controller runs the Euclid remainder steps and then
// the two final divisions before done; a zero denominator goes straight to done.
// Each remainder step and each final division runs through one shared bit-serial divider.
// Throughput: one beat at a time; busy falls the cycle after done, when start is taken again.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
// Reset: arst_n returns the controller to idle at once; result registers are not cleared.
module fraction_reduce_core
	import frd_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] numerator,
	input  logic signed [VALUE_WIDTH-1:0] denominator,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] reduced_numerator,
	output logic signed [VALUE_WIDTH-1:0] reduced_denominator,
	output logic                          zero_denominator,
	output logic                          whole_number
);

	frd_cmd_t    cmd;
	frd_status_t status;

	// sequence the gcd loop and divisions
	frd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// operands, shared divider and result registers
	frd_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk                 (clk),
		.numerator           (numerator),
		.denominator         (denominator),
		.cmd                 (cmd),
		.status              (status),
		.reduced_numerator   (reduced_numerator),
		.reduced_denominator (reduced_denominator),
		.zero_denominator    (zero_denominator),
		.whole_number        (whole_number)
	);

endmodule

// File: tb/fraction_reduce_core_tb.sv
module fraction_reduce_core_tb;
	import frd_pkg::*;

	localparam int W = VALUE_WIDTH_DEF;
	localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] MOST_POS = ~MOST_NEG;
	localparam int RANDOM_FRACTIONS = 600;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2 * W + 40;

	// one reduced fraction as it leaves the block
	typedef struct packed {
		logic signed [W-1:0] num;
		logic signed [W-1:0] den;
		logic                zero_den;
		logic                whole;
	} fraction_t;

	// directed beat, with the result typed in where it is obvious
	typedef struct packed {
		logic signed [W-1:0] num;
		logic signed [W-1:0] den;
		logic                has_typed;
		fraction_t           typed;
	} directed_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic signed [W-1:0] numerator;
	logic signed [W-1:0] denominator;
	logic                done;
	logic signed [W-1:0] reduced_numerator;
	logic signed [W-1:0] reduced_denominator;
	logic                zero_denominator;
	logic                whole_number;

	fraction_t     pending_results[$];
	directed_row_t directed_rows[$];
	int            mismatches = 0;
	int            fractions_sent = 0;
	int            results_checked = 0;
	int            zero_den_seen = 0;
	int            whole_seen = 0;
	int            quiet_cycles = 0;

	fraction_reduce_core #(
		.VALUE_WIDTH(W)
	) dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.numerator          (numerator),
		.denominator        (denominator),
		.done               (done),
		.reduced_numerator  (reduced_numerator),
		.reduced_denominator(reduced_denominator),
		.zero_denominator   (zero_denominator),
		.whole_number       (whole_number)
	);

	always #5 clk = ~clk;

	// lowest terms by Euclid on the magnitudes, sign moved onto the numerator
	function automatic fraction_t reduce_fraction(input logic signed [W-1:0] num,
			input logic signed [W-1:0] den);
		logic [W-1:0] mag_n;
		logic [W-1:0] mag_d;
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic [W-1:0] r;
		logic [W-1:0] q_n;
		logic [W-1:0] q_d;
		fraction_t    res;
		if (den == '0) begin
			res.num      = num;
			res.den      = '0;
			res.zero_den = 1'b1;
			res.whole    = 1'b0;
			return res;
		end
		mag_n = num;
		if (num[W-1]) mag_n = -mag_n;
		mag_d = den;
		if (den[W-1]) mag_d = -mag_d;
		x = mag_d;
		y = mag_n;
		while (y != '0) begin
			r = x % y;
			x = y;
			y = r;
		end
		q_n = mag_n / x;
		q_d = mag_d / x;
		res.num      = ((num[W-1] != den[W-1]) && (q_n != '0)) ? -q_n : q_n;
		res.den      = q_d;
		res.zero_den = 1'b0;
		res.whole    = (q_d == 1);
		return res;
	endfunction

	function automatic directed_row_t row(input logic signed [W-1:0] num,
			input logic signed [W-1:0] den, input logic has_typed,
			input logic signed [W-1:0] exp_num, input logic signed [W-1:0] exp_den,
			input logic exp_zero_den, input logic exp_whole);
		directed_row_t d;
		d.num            = num;
		d.den            = den;
		d.has_typed      = has_typed;
		d.typed.num      = exp_num;
		d.typed.den      = exp_den;
		d.typed.zero_den = exp_zero_den;
		d.typed.whole    = exp_whole;
		return d;
	endfunction

	function automatic logic signed [W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return -MOST_POS;
			3: return 1;
			4: return -1;
			default: return 0;
		endcase
	endfunction

	// half shared factors and small values, the rest raw words, zero parts and edge cases
	task automatic draw_fraction(output logic signed [W-1:0] num,
			output logic signed [W-1:0] den);
		int          pick;
		logic [W-1:0] factor;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			num = $urandom;
			den = $urandom;
		end else if (pick < 65) begin
			factor = $urandom_range(1, 65535);
			num = factor * $urandom_range(0, 32767);
			den = factor * $urandom_range(1, 32767);
		end else if (pick < 80) begin
			num = $urandom_range(0, 40);
			den = $urandom_range(0, 40);
		end else if (pick < 88) begin
			num = $urandom;
			den = '0;
		end else if (pick < 94) begin
			num = '0;
			den = $urandom;
		end else begin
			num = pick_extreme();
			den = pick_extreme();
		end
		if ($urandom_range(0, 1)) num = -num;
		if ($urandom_range(0, 1)) den = -den;
	endtask

	// offer one beat, optionally after an idle gap, and hold it until taken
	task automatic offer_fraction(input logic signed [W-1:0] num,
			input logic signed [W-1:0] den, input fraction_t predicted, input bit idling);
		if (idling && $urandom_range(0, 99) < 16) begin
			start <= 1'b0;
			@(posedge clk);
			while (busy) @(posedge clk);
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
		start       <= 1'b1;
		numerator   <= num;
		denominator <= den;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predicted);
		fractions_sent++;
	endtask

	task automatic report_mismatch(input string field, input logic signed [W-1:0] want,
			input logic signed [W-1:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, got %0d/%0d", $time,
					reduced_numerator, reduced_denominator);
			end else begin
				want = pending_results.pop_front();
				if (reduced_numerator !== want.num)
					report_mismatch("reduced_numerator", want.num, reduced_numerator);
				if (reduced_denominator !== want.den)
					report_mismatch("reduced_denominator", want.den, reduced_denominator);
				if (zero_denominator !== want.zero_den)
					report_mismatch("zero_denominator", want.zero_den, zero_denominator);
				if (whole_number !== want.whole)
					report_mismatch("whole_number", want.whole, whole_number);
				results_checked++;
				if (want.zero_den) zero_den_seen++;
				if (want.whole) whole_seen++;
			end
		end
	end

	// end the run if nothing is taken or returned for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done === 1'b1)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("fraction_reduce_core_tb failed");
				$finish;
			end
		end
	end

	initial begin
		logic signed [W-1:0] num;
		logic signed [W-1:0] den;
		fraction_t           predicted;
		arst_n      = 1'b0;
		start       = 1'b0;
		numerator   = '0;
		denominator = '0;

		// obvious cases carry their result, the rest go through the predictor
		directed_rows.push_back(row(0, 5, 1, 0, 1, 0, 1));
		directed_rows.push_back(row(7, 0, 1, 7, 0, 1, 0));
		directed_rows.push_back(row(0, 0, 1, 0, 0, 1, 0));
		directed_rows.push_back(row(MOST_NEG, 0, 1, MOST_NEG, 0, 1, 0));
		directed_rows.push_back(row(MOST_POS, 1, 1, MOST_POS, 1, 0, 1));
		directed_rows.push_back(row(-MOST_POS, -1, 1, MOST_POS, 1, 0, 1));
		directed_rows.push_back(row(MOST_POS, -MOST_POS, 1, -1, 1, 0, 1));
		directed_rows.push_back(row(1, -MOST_POS, 1, -1, MOST_POS, 0, 0));
		directed_rows.push_back(row(MOST_NEG, -1, 1, MOST_NEG, 1, 0, 1));
		directed_rows.push_back(row(MOST_NEG, MOST_NEG, 1, 1, 1, 0, 1));
		directed_rows.push_back(row(1, MOST_NEG, 1, -1, MOST_NEG, 0, 0));
		directed_rows.push_back(row(6, -4, 1, -3, 2, 0, 0));
		directed_rows.push_back(row(-6, 4, 1, -3, 2, 0, 0));
		directed_rows.push_back(row(12, -12, 1, -1, 1, 0, 1));
		directed_rows.push_back(row(0, -7, 1, 0, 1, 0, 1));
		directed_rows.push_back(row(-1, -1, 1, 1, 1, 0, 1));
		directed_rows.push_back(row(1836311903, 1134903170, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(-1134903170, 1836311903, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(1073741824, 536870912, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(1431655765, -715827882, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(MOST_NEG, 2, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(-MOST_POS, MOST_NEG, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(MOST_NEG, MOST_POS, 0, 0, 0, 0, 0));
		directed_rows.push_back(row(999999937, -999999929, 0, 0, 0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		foreach (directed_rows[i]) begin
			predicted = directed_rows[i].has_typed ? directed_rows[i].typed
				: reduce_fraction(directed_rows[i].num, directed_rows[i].den);
			offer_fraction(directed_rows[i].num, directed_rows[i].den, predicted, 1'b1);
		end

		// random beats, with a stretch in the middle sent back to back
		for (int i = 0; i < RANDOM_FRACTIONS; i++) begin
			draw_fraction(num, den);
			offer_fraction(num, den, reduce_fraction(num, den), !(i >= 250 && i < 400));
		end

		// drop start, drain outstanding results and watch for strays
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d fractions, checked %0d results", fractions_sent, results_checked);
		$display("of those %0d had a zero denominator and %0d reduced to whole numbers",
			zero_den_seen, whole_seen);
		if (mismatches == 0) begin
			$display("fraction_reduce_core_tb passed");
		end else begin
			$display("fraction_reduce_core_tb failed");
		end
		$finish;
	end

endmodule
